// ===== rtl/ufp_pkg.sv =====
package ufp_pkg;

    // Command bytes that open a frame.
    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_CHUNK = 8'h02;
    localparam logic [7:0] CMD_END   = 8'h03;

    // Reset value of the chunk length limit.
    localparam logic [15:0] MAX_CHUNK_RESET = 16'd1021;

    // Input operation codes.
    localparam logic OP_BYTE       = 1'b0;
    localparam logic OP_LINK_RESET = 1'b1;

    // Frame answered by a response.
    localparam logic [1:0] RESP_START = 2'd0;
    localparam logic [1:0] RESP_CHUNK = 2'd1;
    localparam logic [1:0] RESP_END   = 2'd2;

    // Header byte counts, as last index.
    localparam logic [1:0] START_HDR_LAST = 2'd3;
    localparam logic [1:0] CHUNK_HDR_LAST = 2'd1;

    // Action queue between parser and executor.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Parser phase.
    typedef enum logic [1:0] {
        PH_COMMAND   = 2'd0,
        PH_START_HDR = 2'd1,
        PH_CHUNK_HDR = 2'd2,
        PH_PAYLOAD   = 2'd3
    } phase_t;

    // Classified actions handed to the executor.
    typedef enum logic [2:0] {
        ACT_LINK_RESET  = 3'd0,
        ACT_START       = 3'd1,
        ACT_CHUNK_LONG  = 3'd2,
        ACT_CHUNK_EMPTY = 3'd3,
        ACT_PAYLOAD     = 3'd4,
        ACT_END         = 3'd5
    } act_kind_t;

    typedef struct packed {
        act_kind_t   kind;
        logic [31:0] data;   // announced size, or payload byte in the low bits
        logic        last;   // final payload byte of a chunk
    } action_t;

endpackage

// ===== rtl/ufp_if.sv =====
// Input byte channel.
interface ufp_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] byte_value;

    modport source (output valid, output operation, output byte_value, input ready);
    modport sink   (input valid, input operation, input byte_value, output ready);
endinterface

// Result channel.
interface ufp_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        response_valid;
    logic        response_nak;
    logic [1:0]  response_to;
    logic        size_match;
    logic        update_done;
    logic [31:0] bytes_count;
    logic [31:0] chunks_count;

    modport source (
        output valid, output payload_valid, output payload_byte, output response_valid,
        output response_nak, output response_to, output size_match, output update_done,
        output bytes_count, output chunks_count, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input response_valid,
        input response_nak, input response_to, input size_match, input update_done,
        input bytes_count, input chunks_count, output ready
    );
endinterface

// Configuration write channel for the chunk length limit.
interface ufp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_chunk_len;

    modport source (output valid, output max_chunk_len, input ready);
    modport sink   (input valid, input max_chunk_len, output ready);
endinterface

// ===== rtl/update_frame_parser.sv =====
// Firmware-update frame parser.
// The req channel takes one transfer per cycle unless the queue is full:
// operation 0 carries a stream byte, operation 1 is a link open or close that
// returns the parser to idle. The rsp channel delivers at most one result per
// input byte: a payload byte to store, a response (ACK or NAK with the frame it
// answers), or both on the last byte of a chunk, together with the saturating
// byte and chunk counts. The cfg channel writes the chunk length limit; it is
// always ready; the user must see that it is written only while the block is
// idle, as the block does not enforce this. Throughput is one byte per cycle
// while the action queue has room. A byte that causes a result passes through
// the action queue and then the output register before it appears on rsp.
// Bytes that cause no result are consumed silently. A four-entry action queue
// separates the byte parser from the executor, so when rsp stalls the parser
// keeps taking bytes until the queue fills, and req.ready then drops until the
// receiver drains results again. Reset clears all parser and transfer state,
// empties the queue and sets the chunk length limit to 1021.
module update_frame_parser
    import ufp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ufp_in_if.sink    req,
    ufp_cfg_if.sink   cfg,
    ufp_out_if.source rsp
);

    logic    push;
    action_t push_act;
    logic    queue_full;
    logic    queue_not_empty;
    action_t head;
    logic    pop;

    // Front end: byte parsing and classification.
    ufp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_act   (push_act)
    );

    // Action queue between the two halves.
    ufp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_act  (push_act),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // Back end: transfer state, counters and result register.
    ufp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .act_valid (queue_not_empty),
        .act       (head),
        .act_pop   (pop),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/ufp_front.sv =====
module ufp_front
    import ufp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ufp_in_if.sink       req,
    ufp_cfg_if.sink      cfg,
    input  logic         queue_full,
    output logic         push,
    output action_t      push_act
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  index_reg, index_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] max_len_reg;
    logic [31:0] shifted;
    logic        accept;

    assign req.ready = !queue_full;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign shifted   = {shift_reg[23:0], req.byte_value};

    // Limit register, written through the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_CHUNK_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_len_reg <= cfg.max_chunk_len;
        end
    end

    // Phase tracking and classification of each transferred byte.
    always_comb
    begin
        phase_next    = phase_reg;
        index_next    = index_reg;
        shift_next    = shift_reg;
        left_next     = left_reg;
        push          = 1'b0;
        push_act.kind = ACT_END;
        push_act.data = 32'd0;
        push_act.last = 1'b0;
        if (accept)
        begin
            if (req.operation == OP_LINK_RESET)
            begin
                phase_next    = PH_COMMAND;
                index_next    = 2'd0;
                shift_next    = 32'd0;
                left_next     = 16'd0;
                push          = 1'b1;
                push_act.kind = ACT_LINK_RESET;
            end
            else
            begin
                unique case (phase_reg)
                    PH_COMMAND:
                    begin
                        index_next = 2'd0;
                        shift_next = 32'd0;
                        if (req.byte_value == CMD_START)
                        begin
                            phase_next = PH_START_HDR;
                        end
                        else if (req.byte_value == CMD_CHUNK)
                        begin
                            phase_next = PH_CHUNK_HDR;
                        end
                        else if (req.byte_value == CMD_END)
                        begin
                            push          = 1'b1;
                            push_act.kind = ACT_END;
                        end
                    end
                    PH_START_HDR:
                    begin
                        shift_next = shifted;
                        index_next = index_reg + 2'd1;
                        if (index_reg == START_HDR_LAST)
                        begin
                            phase_next    = PH_COMMAND;
                            index_next    = 2'd0;
                            push          = 1'b1;
                            push_act.kind = ACT_START;
                            push_act.data = shifted;
                        end
                    end
                    PH_CHUNK_HDR:
                    begin
                        shift_next = shifted;
                        index_next = index_reg + 2'd1;
                        if (index_reg == CHUNK_HDR_LAST)
                        begin
                            phase_next = PH_COMMAND;
                            index_next = 2'd0;
                            if (shifted[15:0] > max_len_reg)
                            begin
                                push          = 1'b1;
                                push_act.kind = ACT_CHUNK_LONG;
                            end
                            else if (shifted[15:0] == 16'd0)
                            begin
                                push          = 1'b1;
                                push_act.kind = ACT_CHUNK_EMPTY;
                            end
                            else
                            begin
                                left_next  = shifted[15:0];
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        push          = 1'b1;
                        push_act.kind = ACT_PAYLOAD;
                        push_act.data = {24'd0, req.byte_value};
                        push_act.last = (left_reg == 16'd1);
                        left_next     = left_reg - 16'd1;
                        if (left_reg == 16'd1)
                        begin
                            phase_next = PH_COMMAND;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_COMMAND;
                    end
                endcase
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COMMAND;
            index_reg <= 2'd0;
            shift_reg <= 32'd0;
            left_reg  <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== rtl/ufp_queue.sv =====
module ufp_queue
    import ufp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  action_t push_act,
    input  logic    pop,
    output logic    full,
    output logic    not_empty,
    output action_t head
);

    action_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_act;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> count_reg == QCNT_W'(QUEUE_DEPTH))
        else $error("queue count changed while full without a pop");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty && !push |=> !not_empty)
        else $error("queue became non-empty without a push");
`endif

endmodule

// ===== rtl/ufp_back.sv =====
module ufp_back
    import ufp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     act_valid,
    input  action_t  act,
    output logic     act_pop,
    ufp_out_if.source rsp
);

    logic        mode_reg, mode_next;
    logic [31:0] expected_reg, expected_next;
    logic [31:0] received_reg, received_next;
    logic [31:0] chunks_reg, chunks_next;

    logic        out_valid_reg;
    logic        pv, rv, nak, match, done;
    logic [7:0]  pb;
    logic [1:0]  to;
    logic        has_result;

    logic        o_pv_reg, o_rv_reg, o_nak_reg, o_match_reg, o_done_reg;
    logic [7:0]  o_pb_reg;
    logic [1:0]  o_to_reg;
    logic [31:0] o_bytes_reg, o_chunks_reg;

    // An action is executed when the output register is free or being drained.
    assign act_pop = act_valid && (!out_valid_reg || rsp.ready);

    // Execution of one action against the transfer state.
    always_comb
    begin
        mode_next     = mode_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        chunks_next   = chunks_reg;
        pv            = 1'b0;
        pb            = 8'd0;
        rv            = 1'b0;
        nak           = 1'b0;
        to            = RESP_START;
        match         = 1'b0;
        done          = 1'b0;
        unique case (act.kind)
            ACT_LINK_RESET:
            begin
                mode_next     = 1'b0;
                expected_next = 32'd0;
                received_next = 32'd0;
                chunks_next   = 32'd0;
            end
            ACT_START:
            begin
                rv = 1'b1;
                to = RESP_START;
                if (mode_reg)
                begin
                    nak = 1'b1;
                end
                else
                begin
                    mode_next     = 1'b1;
                    expected_next = act.data;
                    received_next = 32'd0;
                    chunks_next   = 32'd0;
                end
            end
            ACT_CHUNK_LONG:
            begin
                rv  = 1'b1;
                nak = 1'b1;
                to  = RESP_CHUNK;
            end
            ACT_CHUNK_EMPTY:
            begin
                rv = 1'b1;
                to = RESP_CHUNK;
                if (mode_reg)
                begin
                    chunks_next = (&chunks_reg) ? chunks_reg : chunks_reg + 32'd1;
                end
                else
                begin
                    nak = 1'b1;
                end
            end
            ACT_PAYLOAD:
            begin
                if (mode_reg)
                begin
                    pv            = 1'b1;
                    pb            = act.data[7:0];
                    received_next = (&received_reg) ? received_reg : received_reg + 32'd1;
                end
                if (act.last)
                begin
                    rv = 1'b1;
                    to = RESP_CHUNK;
                    if (mode_reg)
                    begin
                        chunks_next = (&chunks_reg) ? chunks_reg : chunks_reg + 32'd1;
                    end
                    else
                    begin
                        nak = 1'b1;
                    end
                end
            end
            ACT_END:
            begin
                rv = 1'b1;
                to = RESP_END;
                if (mode_reg)
                begin
                    match     = (received_reg == expected_reg);
                    done      = 1'b1;
                    mode_next = 1'b0;
                end
                else
                begin
                    nak = 1'b1;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
        has_result = pv || rv;
    end

    // Transfer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            expected_reg <= 32'd0;
            received_reg <= 32'd0;
            chunks_reg   <= 32'd0;
        end
        else if (act_pop)
        begin
            mode_reg     <= mode_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            chunks_reg   <= chunks_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (act_pop)
        begin
            out_valid_reg <= has_result;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (act_pop && has_result)
        begin
            o_pv_reg     <= pv;
            o_pb_reg     <= pb;
            o_rv_reg     <= rv;
            o_nak_reg    <= nak;
            o_to_reg     <= to;
            o_match_reg  <= match;
            o_done_reg   <= done;
            o_bytes_reg  <= received_next;
            o_chunks_reg <= chunks_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.payload_valid  = o_pv_reg;
    assign rsp.payload_byte   = o_pb_reg;
    assign rsp.response_valid = o_rv_reg;
    assign rsp.response_nak   = o_nak_reg;
    assign rsp.response_to    = o_to_reg;
    assign rsp.size_match     = o_match_reg;
    assign rsp.update_done    = o_done_reg;
    assign rsp.bytes_count    = o_bytes_reg;
    assign rsp.chunks_count   = o_chunks_reg;

`ifndef SYNTHESIS
    a_done_is_end_ack: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.update_done |->
            rsp.response_valid && !rsp.response_nak && rsp.response_to == RESP_END)
        else $error("update_done outside an end acknowledge");
    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.payload_valid || rsp.response_valid)
        else $error("result carries neither payload nor response");
    a_link_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        act_pop && act.kind == ACT_LINK_RESET |=>
            !mode_reg && received_reg == 32'd0 && chunks_reg == 32'd0)
        else $error("link reset left transfer state behind");
    a_payload_only_receiving: assert property (@(posedge clk) disable iff (!rst_n)
        act_pop && act.kind == ACT_PAYLOAD && !mode_reg |=> !out_valid_reg || !o_pv_reg)
        else $error("payload passed out outside a transfer");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ufp_pkg::*;

    localparam int PHASE_ITEMS  = 240;
    localparam int SETTLE       = 8;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PRINT_LIMIT  = 40;

    // One result as seen on the rsp channel.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        response_valid;
        logic        response_nak;
        logic [1:0]  response_to;
        logic        size_match;
        logic        update_done;
        logic [31:0] bytes_count;
        logic [31:0] chunks_count;
    } reply_t;

    // Tracks the parser state, predicts replies and checks them in order.
    class frame_scoreboard;
        reply_t    pending_replies[$];
        int        errors;
        int        inputs_seen;
        int        results_seen;
        int        responses_seen;
        int        naks_seen;
        int        updates_done;
        int        sizes_matched;

        bit [15:0] chunk_limit;
        bit        receiving;
        phase_t    phase;
        bit [2:0]  hdr_count;
        bit [31:0] hdr_shift;
        bit [15:0] payload_remaining;
        bit        discarding;
        bit [31:0] announced_size;
        bit [31:0] byte_total;
        bit [31:0] chunk_tally;

        function new();
            chunk_limit = MAX_CHUNK_RESET;
            clear_parser();
        endfunction

        function void clear_parser();
            receiving         = 1'b0;
            phase             = PH_COMMAND;
            hdr_count         = '0;
            hdr_shift         = '0;
            payload_remaining = '0;
            discarding        = 1'b0;
            announced_size    = '0;
            byte_total        = '0;
            chunk_tally       = '0;
        endfunction

        function bit [31:0] sat_inc(bit [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        function void set_limit(bit [15:0] v);
            chunk_limit = v;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // Advances the parser by one byte; returns 1 when the byte yields a reply.
        function bit parse_byte(bit op, bit [7:0] b, output reply_t r);
            bit [15:0] len;
            r = '0;
            if (op == OP_LINK_RESET) begin
                clear_parser();
                return 1'b0;
            end
            case (phase)
                PH_START_HDR: begin
                    hdr_shift = {hdr_shift[23:0], b};
                    hdr_count = hdr_count + 3'd1;
                    if (hdr_count >= 3'd4) begin
                        r.response_valid = 1'b1;
                        r.response_to    = RESP_START;
                        if (receiving) begin
                            r.response_nak = 1'b1;
                        end
                        else begin
                            receiving      = 1'b1;
                            announced_size = hdr_shift;
                            byte_total     = '0;
                            chunk_tally    = '0;
                        end
                        phase     = PH_COMMAND;
                        hdr_count = '0;
                    end
                end
                PH_CHUNK_HDR: begin
                    hdr_shift = {hdr_shift[23:0], b};
                    hdr_count = hdr_count + 3'd1;
                    if (hdr_count >= 3'd2) begin
                        len       = hdr_shift[15:0];
                        hdr_count = '0;
                        phase     = PH_COMMAND;
                        if (len > chunk_limit) begin
                            r.response_valid = 1'b1;
                            r.response_nak   = 1'b1;
                            r.response_to    = RESP_CHUNK;
                        end
                        else if (len == 16'd0) begin
                            r.response_valid = 1'b1;
                            r.response_to    = RESP_CHUNK;
                            if (receiving)
                                chunk_tally = sat_inc(chunk_tally);
                            else
                                r.response_nak = 1'b1;
                        end
                        else begin
                            payload_remaining = len;
                            discarding        = !receiving;
                            phase             = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (payload_remaining != 16'd0)
                        payload_remaining = payload_remaining - 16'd1;
                    if (!discarding) begin
                        r.payload_valid = 1'b1;
                        r.payload_byte  = b;
                        byte_total      = sat_inc(byte_total);
                    end
                    if (payload_remaining == 16'd0) begin
                        r.response_valid = 1'b1;
                        r.response_to    = RESP_CHUNK;
                        if (discarding)
                            r.response_nak = 1'b1;
                        else
                            chunk_tally = sat_inc(chunk_tally);
                        discarding = 1'b0;
                        phase      = PH_COMMAND;
                    end
                end
                default: begin
                    phase     = PH_COMMAND;
                    hdr_count = '0;
                    hdr_shift = '0;
                    if (b == CMD_START) begin
                        phase = PH_START_HDR;
                    end
                    else if (b == CMD_CHUNK) begin
                        phase = PH_CHUNK_HDR;
                    end
                    else if (b == CMD_END) begin
                        r.response_valid = 1'b1;
                        r.response_to    = RESP_END;
                        if (receiving) begin
                            r.size_match  = (byte_total == announced_size);
                            r.update_done = 1'b1;
                            receiving     = 1'b0;
                        end
                        else begin
                            r.response_nak = 1'b1;
                        end
                    end
                end
            endcase
            if (!r.payload_valid && !r.response_valid)
                return 1'b0;
            r.bytes_count  = byte_total;
            r.chunks_count = chunk_tally;
            return 1'b1;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("tb_top: mismatch: %s", msg);
            errors++;
        endtask

        // Notes one accepted input transfer and queues its reply, if any.
        task take_byte(logic op, logic [7:0] b);
            reply_t r;
            inputs_seen++;
            if (parse_byte(op, b, r)) begin
                pending_replies.push_back(r);
                if (r.response_valid) responses_seen++;
                if (r.response_nak) naks_seen++;
                if (r.update_done) updates_done++;
                if (r.size_match) sizes_matched++;
            end
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s is %0h, expected %0h",
                                 results_seen, name, got, want));
        endtask

        // Checks one accepted result against the oldest expected reply.
        task check_result(reply_t got);
            reply_t want;
            results_seen++;
            if (pending_replies.size() == 0) begin
                report($sformatf("result %0d arrived with no reply expected", results_seen));
                return;
            end
            want = pending_replies.pop_front();
            compare_field("payload_valid", got.payload_valid, want.payload_valid);
            compare_field("payload_byte", got.payload_byte, want.payload_byte);
            compare_field("response_valid", got.response_valid, want.response_valid);
            compare_field("response_nak", got.response_nak, want.response_nak);
            compare_field("response_to", got.response_to, want.response_to);
            compare_field("size_match", got.size_match, want.size_match);
            compare_field("update_done", got.update_done, want.update_done);
            compare_field("bytes_count", got.bytes_count, want.bytes_count);
            compare_field("chunks_count", got.chunks_count, want.chunks_count);
        endtask

        task check_drained();
            if (pending_replies.size() != 0)
                report($sformatf("%0d expected replies never arrived",
                                 pending_replies.size()));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ufp_in_if  req_if ();
    ufp_cfg_if cfg_if ();
    ufp_out_if rsp_if ();

    update_frame_parser u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .cfg   (cfg_if),
        .rsp   (rsp_if)
    );

    frame_scoreboard sb = new();

    bit        tx_steady;
    bit        rx_steady;
    bit [15:0] cur_limit = MAX_CHUNK_RESET;
    int        sent_items;
    int        noise_items;
    int        limit_writes;

    always #6 clk = ~clk;

    // Observe every transfer on all three channels.
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (req_if.valid && req_if.ready)
                sb.take_byte(req_if.operation, req_if.byte_value);
            if (cfg_if.valid && cfg_if.ready)
                sb.set_limit(cfg_if.max_chunk_len);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(reply_t'{rsp_if.payload_valid, rsp_if.payload_byte,
                                         rsp_if.response_valid, rsp_if.response_nak,
                                         rsp_if.response_to, rsp_if.size_match,
                                         rsp_if.update_done, rsp_if.bytes_count,
                                         rsp_if.chunks_count});
        end
    end

    // Result receiver with random stalls and occasional stall-free stretches.
    initial begin
        int gap;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 59) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (rsp_if.valid !== 1'b1);
        end
    end

    // Drives one input item after a random gap and waits for its transfer.
    task automatic send_item(bit op, bit [7:0] b);
        int gap;
        if ($urandom_range(0, 59) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.byte_value <= b;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        sent_items++;
    endtask

    task automatic send_byte(bit [7:0] b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_u16(bit [15:0] v);
        send_byte(v[15:8]);
        send_byte(v[7:0]);
    endtask

    task automatic send_u32(bit [31:0] v);
        send_u16(v[31:16]);
        send_u16(v[15:0]);
    endtask

    task automatic send_link_reset();
        send_item(OP_LINK_RESET, $urandom_range(0, 255));
    endtask

    // Stops sending until every expected reply has arrived and the block is idle.
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(bit [15:0] v);
        cfg_if.valid         <= 1'b1;
        cfg_if.max_chunk_len <= v;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        cur_limit = v;
        limit_writes++;
    endtask

    // A full update session: start, a few chunks, end, with occasional faults.
    task automatic send_session();
        bit [15:0] lens[$];
        bit [15:0] len;
        bit [31:0] size;
        int        total;
        int        pick;
        total = 0;
        repeat ($urandom_range(0, 4)) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                len = 16'd0;
            else if (pick < 70)
                len = $urandom_range(1, 12);
            else if (pick < 80 && cur_limit <= 16'd64)
                len = cur_limit;
            else if (pick < 95 && cur_limit != 16'hFFFF)
                len = $urandom_range(int'(cur_limit) + 1, 65535);
            else
                len = $urandom_range(13, 40);
            lens.push_back(len);
            if (len <= cur_limit)
                total += len;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
            size = total;
        else if (pick < 8)
            size = total + 1;
        else
            size = $urandom();
        if ($urandom_range(0, 3) == 0)
            send_link_reset();
        send_byte(CMD_START);
        send_u32(size);
        foreach (lens[i]) begin
            // A stray start inside the session is refused without side effects.
            if ($urandom_range(0, 19) == 0) begin
                send_byte(CMD_START);
                send_u32($urandom());
            end
            send_byte(CMD_CHUNK);
            send_u16(lens[i]);
            if (lens[i] <= cur_limit)
                repeat (lens[i]) send_byte($urandom_range(0, 255));
            else if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 255));
        end
        if ($urandom_range(0, 15) != 0)
            send_byte(CMD_END);
    endtask

    // A chunk or end frame sent while no session is open.
    task automatic send_orphan();
        bit [15:0] len;
        if ($urandom_range(0, 1) == 0)
            send_link_reset();
        if ($urandom_range(0, 1) == 0) begin
            send_byte(CMD_END);
        end
        else begin
            len = $urandom_range(0, 12);
            send_byte(CMD_CHUNK);
            send_u16(len);
            repeat (len) send_byte($urandom_range(0, 255));
        end
    endtask

    // A frame cut short by a link reset.
    task automatic send_truncated();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            send_byte(CMD_START);
            repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 255));
        end
        else if (pick == 1) begin
            send_byte(CMD_CHUNK);
            if ($urandom_range(0, 1) == 1)
                send_byte($urandom_range(0, 255));
        end
        else begin
            send_byte(CMD_START);
            send_u32($urandom_range(1, 64));
            send_byte(CMD_CHUNK);
            send_u16(16'd8);
            repeat ($urandom_range(0, 7)) send_byte($urandom_range(0, 255));
        end
        send_link_reset();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            send_byte($urandom_range(0, 255));
            noise_items++;
        end
        if ($urandom_range(0, 3) != 0)
            send_link_reset();
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 62)
            send_session();
        else if (pick < 74)
            send_orphan();
        else if (pick < 86)
            send_truncated();
        else
            send_noise();
        if ($urandom_range(0, 39) == 0)
            wait_idle();
    endtask

    // Main stimulus: reset, directed frames, then random phases per limit.
    initial begin
        bit [15:0] phase_limits[6];
        int        target;
        int        waited;
        rst_n                <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.operation     <= OP_BYTE;
        req_if.byte_value    <= 8'h00;
        cfg_if.valid         <= 1'b0;
        cfg_if.max_chunk_len <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End and chunk outside a session are refused.
        send_byte(CMD_END);
        send_byte(CMD_CHUNK);
        send_u16(16'd1);
        send_byte(8'h7E);
        // Accepted start announcing one byte, then a refused second start.
        send_byte(CMD_START);
        send_u32(32'd1);
        send_byte(CMD_START);
        send_u32(32'hFFFF_FFFF);
        // Over-long length, empty chunk, and a one-byte chunk.
        send_byte(CMD_CHUNK);
        send_u16(16'hFFFF);
        send_byte(CMD_CHUNK);
        send_u16(16'h0000);
        send_byte(CMD_CHUNK);
        send_u16(16'd1);
        send_byte(8'hFF);
        // Unknown command byte is dropped; end completes with matching size.
        send_byte(8'hFE);
        send_byte(CMD_END);
        send_item(OP_LINK_RESET, 8'hFF);

        phase_limits = '{16'd0, 16'hFFFF, 16'd3, 16'd12, 16'd0, MAX_CHUNK_RESET};
        phase_limits[4] = $urandom_range(4, 64);
        foreach (phase_limits[i]) begin
            wait_idle();
            write_limit(phase_limits[i]);
            target = sent_items - noise_items + PHASE_ITEMS;
            while (sent_items - noise_items < target)
                random_sequence();
        end

        // Drain outstanding replies, then give silent bytes time to settle.
        req_if.valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        sb.check_drained();

        $display("tb_top: %0d input transfers, %0d results, %0d responses of which %0d NAK",
                 sb.inputs_seen, sb.results_seen, sb.responses_seen, sb.naks_seen);
        $display("tb_top: %0d limit writes, %0d completed updates, %0d with matching size",
                 limit_writes, sb.updates_done, sb.sizes_matched);
        if (sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== update_frame_parser.f =====
rtl/ufp_pkg.sv
rtl/ufp_if.sv
rtl/ufp_front.sv
rtl/ufp_queue.sv
rtl/ufp_back.sv
rtl/update_frame_parser.sv
tb/tb_top.sv
